/* rtl/core/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants for the complex arithmetic unit.
// Word format, operation codes and the division pipeline geometry.
// ----------------------------------------------------------------------------
`default_nettype none
package cau_pkg;
	localparam int FRAC_BITS = 8;
	localparam int WORD_BITS = 16;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int MAG_BITS  = PROD_BITS + 1;
	localparam int QUO_BITS  = WORD_BITS + 1;
	localparam int DIV_STEPS = QUO_BITS;

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_SUB = 2'd1;
	localparam logic [1:0] ACT_MUL = 2'd2;
	localparam logic [1:0] ACT_DIV = 2'd3;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [MAG_BITS-1:0] mag_t;
	typedef logic [MAG_BITS-1:0] den_t;
	typedef logic [QUO_BITS-1:0] quo_t;

	typedef struct packed {
		logic [1:0] action;
		logic       sat;
		logic       dz;
		logic       neg_re;
		logic       neg_im;
	} ctl_t;

	// Saturate a sign and magnitude value to the word range.
	function automatic word_t sat_sm(input logic neg, input mag_t mag, output logic flag);
		mag_t lim;
		word_t r;
		lim = mag_t'(1) << (WORD_BITS - 1);
		flag = 1'b0;
		if (neg) begin
			if (mag > lim) begin
				flag = 1'b1;
				r = word_t'(lim);
			end else begin
				r = word_t'(-mag);
			end
		end else begin
			if (mag > lim - mag_t'(1)) begin
				flag = 1'b1;
				r = word_t'(lim - mag_t'(1));
			end else begin
				r = word_t'(mag);
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/core/cau_if.sv */
// ----------------------------------------------------------------------------
// cau_if: valid/ready channels for requests and results.
// One interface for operand requests, one for results.
// ----------------------------------------------------------------------------
`default_nettype none
interface cau_req_if import cau_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] action;
	word_t      a_re;
	word_t      a_im;
	word_t      b_re;
	word_t      b_im;
	modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
	modport sink (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_res_if import cau_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t res_re;
	word_t res_im;
	logic  saturated;
	logic  div_by_zero;
	modport source (output valid, res_re, res_im, saturated, div_by_zero, input ready);
	modport sink (input valid, res_re, res_im, saturated, div_by_zero, output ready);
endinterface
`default_nettype wire

/* rtl/core/cau_front.sv */
// ----------------------------------------------------------------------------
// cau_front: operand products and sums.
// Stage 1 has four cross products, b squares, sums; stage 2 sign/magnitude.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_front import cau_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire logic [1:0] action,
	input  wire word_t a_re,
	input  wire word_t a_im,
	input  wire word_t b_re,
	input  wire word_t b_im,
	output logic  valid_s2,
	output ctl_t  ctl_s2,
	output mag_t  mag_re_s2,
	output mag_t  mag_im_s2,
	output den_t  den_s2
);
	logic signed [PROD_BITS-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, d_rr_s1, d_ii_s1;
	logic signed [WORD_BITS:0] s_re_s1, s_im_s1;
	logic [1:0] act_s1;
	logic valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1  <= action;
			p_rr_s1 <= a_re * b_re;
			p_ii_s1 <= a_im * b_im;
			p_ri_s1 <= a_re * b_im;
			p_ir_s1 <= a_im * b_re;
			d_rr_s1 <= b_re * b_re;
			d_ii_s1 <= b_im * b_im;
			if (action == ACT_SUB) begin
				s_re_s1 <= (WORD_BITS+1)'(a_re) - (WORD_BITS+1)'(b_re);
				s_im_s1 <= (WORD_BITS+1)'(a_im) - (WORD_BITS+1)'(b_im);
			end else begin
				s_re_s1 <= (WORD_BITS+1)'(a_re) + (WORD_BITS+1)'(b_re);
				s_im_s1 <= (WORD_BITS+1)'(a_im) + (WORD_BITS+1)'(b_im);
			end
		end
	end

	logic signed [MAG_BITS:0] t_re, t_im;
	logic signed [MAG_BITS:0] x_rr, x_ii, x_ri, x_ir;
	always_comb begin
		x_rr = (MAG_BITS+1)'(p_rr_s1);
		x_ii = (MAG_BITS+1)'(p_ii_s1);
		x_ri = (MAG_BITS+1)'(p_ri_s1);
		x_ir = (MAG_BITS+1)'(p_ir_s1);
		case (act_s1)
			ACT_ADD, ACT_SUB: begin
				t_re = (MAG_BITS+1)'(s_re_s1) <<< FRAC_BITS;
				t_im = (MAG_BITS+1)'(s_im_s1) <<< FRAC_BITS;
			end
			ACT_MUL: begin
				t_re = x_rr - x_ii;
				t_im = x_ri + x_ir;
			end
			default: begin
				t_re = x_rr + x_ii;
				t_im = x_ir - x_ri;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2.action <= act_s1;
			ctl_s2.sat    <= 1'b0;
			ctl_s2.neg_re <= t_re[MAG_BITS];
			ctl_s2.neg_im <= t_im[MAG_BITS];
			mag_re_s2 <= t_re[MAG_BITS] ? mag_t'(-t_re) : mag_t'(t_re);
			mag_im_s2 <= t_im[MAG_BITS] ? mag_t'(-t_im) : mag_t'(t_im);
			den_s2 <= den_t'($unsigned(d_rr_s1)) + den_t'($unsigned(d_ii_s1));
			ctl_s2.dz <= (act_s1 == ACT_DIV) && (d_rr_s1 == '0) && (d_ii_s1 == '0);
		end
	end
endmodule
`default_nettype wire

/* rtl/core/cau_div.sv */
// ----------------------------------------------------------------------------
// cau_div: pipelined restoring divider for both quotient components.
// One quotient bit per stage; for the other operations the magnitude passes
// through, is shifted down by FRAC_BITS at the end and then saturated.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_div import cau_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire ctl_t ctl_in,
	input  wire mag_t mag_re,
	input  wire mag_t mag_im,
	input  wire den_t den,
	output logic  valid_out,
	output ctl_t  ctl_out,
	output word_t re_out,
	output word_t im_out
);
	localparam int N = DIV_STEPS;
	localparam int RW = MAG_BITS + FRAC_BITS;
	localparam int CW = RW + N;

	// The numerator magnitude is scaled by 2^FRAC_BITS and divided one bit a
	// stage from the top: quotient bit k uses den << k. A quotient of 2^QUO_BITS
	// or more saturates anyway, so the first stage only flags it.
	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_step
			localparam int SH = N - 1 - k;
			// Stage inputs: the block inputs for the first stage, else the
			// registers of the stage before.
			logic          v_i;
			ctl_t          c_i;
			den_t          d_i;
			logic [RW-1:0] rr_i, ri_i;
			quo_t          qr_i, qi_i;
			mag_t          mr_i, mi_i;
			logic          ovr_i, ovi_i;
			// Stage registers: remainder, quotient bits and pass-through magnitude.
			logic          v_q;
			ctl_t          c_q;
			den_t          d_q;
			logic [RW-1:0] rr_q, ri_q;
			quo_t          qr_q, qi_q;
			mag_t          mr_q, mi_q;
			logic          ovr_q, ovi_q;
			logic [CW-1:0] dsh, dtop, rr_w, ri_w;
			logic          ger, gei;

			if (k == 0) begin : g_head
				assign v_i   = valid_in;
				assign c_i   = ctl_in;
				assign d_i   = den;
				assign rr_i  = RW'(mag_re) << FRAC_BITS;
				assign ri_i  = RW'(mag_im) << FRAC_BITS;
				assign qr_i  = '0;
				assign qi_i  = '0;
				assign mr_i  = mag_re;
				assign mi_i  = mag_im;
				assign ovr_i = 1'b0;
				assign ovi_i = 1'b0;
			end else begin : g_body
				assign v_i   = g_step[k-1].v_q;
				assign c_i   = g_step[k-1].c_q;
				assign d_i   = g_step[k-1].d_q;
				assign rr_i  = g_step[k-1].rr_q;
				assign ri_i  = g_step[k-1].ri_q;
				assign qr_i  = g_step[k-1].qr_q;
				assign qi_i  = g_step[k-1].qi_q;
				assign mr_i  = g_step[k-1].mr_q;
				assign mi_i  = g_step[k-1].mi_q;
				assign ovr_i = g_step[k-1].ovr_q;
				assign ovi_i = g_step[k-1].ovi_q;
			end

			always_comb begin
				dsh  = CW'(d_i) << SH;
				dtop = CW'(d_i) << N;
				rr_w = CW'(rr_i);
				ri_w = CW'(ri_i);
				ger  = rr_w >= dsh;
				gei  = ri_w >= dsh;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q <= 1'b0;
				end else if (en) begin
					v_q <= v_i;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					c_q   <= c_i;
					d_q   <= d_i;
					mr_q  <= mr_i;
					mi_q  <= mi_i;
					rr_q  <= ger ? RW'(rr_w - dsh) : rr_i;
					ri_q  <= gei ? RW'(ri_w - dsh) : ri_i;
					qr_q  <= {qr_i[QUO_BITS-2:0], ger};
					qi_q  <= {qi_i[QUO_BITS-2:0], gei};
					ovr_q <= ovr_i || (k == 0 && rr_w >= dtop);
					ovi_q <= ovi_i || (k == 0 && ri_w >= dtop);
				end
			end
		end
	endgenerate

	logic v_n;
	ctl_t c_n;
	quo_t qr_n, qi_n;
	mag_t mr_n, mi_n;
	logic ovr_n, ovi_n;
	assign v_n   = g_step[N-1].v_q;
	assign c_n   = g_step[N-1].c_q;
	assign qr_n  = g_step[N-1].qr_q;
	assign qi_n  = g_step[N-1].qi_q;
	assign mr_n  = g_step[N-1].mr_q;
	assign mi_n  = g_step[N-1].mi_q;
	assign ovr_n = g_step[N-1].ovr_q;
	assign ovi_n = g_step[N-1].ovi_q;

	mag_t vr, vi;
	logic fr, fi;
	word_t wr, wi;
	always_comb begin
		if (c_n.action == ACT_DIV) begin
			vr = ovr_n ? (mag_t'(1) << WORD_BITS) : mag_t'(qr_n);
			vi = ovi_n ? (mag_t'(1) << WORD_BITS) : mag_t'(qi_n);
		end else begin
			vr = mr_n >> FRAC_BITS;
			vi = mi_n >> FRAC_BITS;
		end
		wr = sat_sm(c_n.neg_re, vr, fr);
		wi = sat_sm(c_n.neg_im, vi, fi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= v_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_out.action <= c_n.action;
			ctl_out.dz     <= c_n.dz;
			ctl_out.neg_re <= c_n.neg_re;
			ctl_out.neg_im <= c_n.neg_im;
			ctl_out.sat    <= (fr || fi) && !c_n.dz;
			re_out         <= c_n.dz ? word_t'(0) : wr;
			im_out         <= c_n.dz ? word_t'(0) : wi;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/complex_arith_unit.sv */
// ----------------------------------------------------------------------------
// complex_arith_unit: pipelined complex add, subtract, multiply and divide.
// Signed Q8.8 components with truncation toward zero and saturation.
// ----------------------------------------------------------------------------
// The unit accepts one request per clock unless the result side stalls, and
// returns one result per request, in order. Every request, whatever its
// operation, travels the same pipeline: two stages form the cross products
// and their sign/magnitude sums, then a restoring divider produces one
// quotient bit per stage (seventeen stages), and a final stage saturates the
// components. That makes 20 register stages. The whole pipeline advances
// together whenever the output register is empty or being drained, so a
// stall on the result side holds every request in place and nothing is lost
// or repeated. A divide by zero returns zero with div_by_zero set and
// saturated clear.
`default_nettype none
module complex_arith_unit import cau_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	cau_req_if.sink   req,
	cau_res_if.source res
);
	logic en;
	logic valid_s2;
	ctl_t ctl_s2;
	mag_t mag_re_s2, mag_im_s2;
	den_t den_s2;
	ctl_t ctl_o;
	word_t re_o, im_o;
	logic valid_o;

	// The pipeline moves when the output slot is free or being taken.
	assign en = !valid_o || res.ready;
	assign req.ready = en;

	cau_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(req.valid),
		.action(req.action), .a_re(req.a_re), .a_im(req.a_im),
		.b_re(req.b_re), .b_im(req.b_im),
		.valid_s2(valid_s2), .ctl_s2(ctl_s2),
		.mag_re_s2(mag_re_s2), .mag_im_s2(mag_im_s2), .den_s2(den_s2)
	);

	cau_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(valid_s2),
		.ctl_in(ctl_s2), .mag_re(mag_re_s2), .mag_im(mag_im_s2), .den(den_s2),
		.valid_out(valid_o), .ctl_out(ctl_o), .re_out(re_o), .im_out(im_o)
	);

	assign res.valid       = valid_o;
	assign res.res_re      = re_o;
	assign res.res_im      = im_o;
	assign res.saturated   = ctl_o.sat;
	assign res.div_by_zero = ctl_o.dz;

	// A held result must not change while the sink stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.res_re) && $stable(res.res_im))
		else $error("result changed under stall");
	// A divide-by-zero result is zero and not saturated.
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.div_by_zero |-> res.res_re == 0 && res.res_im == 0 && !res.saturated)
		else $error("bad divide-by-zero result");
	// Requests are refused only while a result is stalled.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> res.valid && !res.ready)
		else $error("pipeline stalled without back pressure");
	// Only divides can report division by zero.
	a_dzact: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.div_by_zero |-> ctl_o.action == ACT_DIV)
		else $error("div_by_zero on non-divide");
endmodule
`default_nettype wire
